[design/csl_pkg.sv]
// Shared types, token codes and character constants for the C subset lexer.
// No dependencies; imported by every lexer module.
`default_nettype none

package csl_pkg;

   // Token codes
   localparam logic [3:0] TOK_EOF        = 4'd0;
   localparam logic [3:0] TOK_SEMI       = 4'd1;
   localparam logic [3:0] TOK_LPAREN     = 4'd2;
   localparam logic [3:0] TOK_RPAREN     = 4'd3;
   localparam logic [3:0] TOK_LBRACE     = 4'd4;
   localparam logic [3:0] TOK_RBRACE     = 4'd5;
   localparam logic [3:0] TOK_SQUIGGLE   = 4'd6;
   localparam logic [3:0] TOK_DASH       = 4'd7;
   localparam logic [3:0] TOK_DECREMENT  = 4'd8;
   localparam logic [3:0] TOK_CONST      = 4'd9;
   localparam logic [3:0] TOK_IDENT      = 4'd10;
   localparam logic [3:0] TOK_INT        = 4'd11;
   localparam logic [3:0] TOK_VOID       = 4'd12;
   localparam logic [3:0] TOK_RETURN     = 4'd13;
   localparam logic [3:0] TOK_BAD        = 4'd14;

   // Characters of interest
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // Largest constant value
   localparam logic [30:0] CONST_MAX = 31'h7FFF_FFFF;

   // Keywords: int, void, return
   localparam int KW_COUNT   = 3;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_LEN_INT    = 3;
   localparam int KW_LEN_VOID   = 4;
   localparam int KW_LEN_RETURN = 6;
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
      '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
   };
   localparam int KW_LEN [KW_COUNT] = '{KW_LEN_INT, KW_LEN_VOID, KW_LEN_RETURN};

   // Queue depth between scanner and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [30:0] constant_value;
      logic        constant_overflow;
      logic [6:0]  ident_length;
      logic [7:0]  offending_char;
      logic [15:0] line_number;
      logic [15:0] column;
      logic        last_of_run;
   } rsp_type;

   // One scanned item: one or two tokens
   typedef struct packed {
      rsp_type tok0;
      rsp_type tok1;
      logic    two;
   } entry_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // Keyword character at a position, zero beyond the keyword's end
   function automatic logic [7:0] kw_char(input int k, input int pos);
      logic [7:0] r;
      r = 8'h00;
      if (pos < KW_MAX_LEN) begin
         r = KW_TEXT[k][pos];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/csl_front.sv]
// Scanner front end: accepts characters, tracks position and token state,
// and pushes one queue entry per item that yields tokens. Uses csl_pkg.
`default_nettype none

module csl_front import csl_pkg::*; #(
   parameter int MAX_IDENT_LEN = 64,
   parameter int LINE_BITS     = 16
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_type   req_data,
   input  wire logic      q_full,
   output logic           push,
   output entry_type      push_entry
);

   localparam int CntW = $clog2(MAX_IDENT_LEN + 1);
   localparam int ExtW = (LINE_BITS > 16) ? LINE_BITS : 16;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NUM, MODE_IDENT, MODE_MINUS, MODE_HALT
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [30:0]            acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [KW_COUNT-1:0]    kw_ff, kw_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [15:0]            col_ff, col_in;

   logic        accept;
   logic [7:0]  c;
   logic        eof;
   rsp_type     base_tok, pend_tok, idle_tok, ident_tok;
   logic        pend_emit, idle_emit, do_idle;
   mode_type    idle_mode;
   logic        idle_digit, idle_word;
   logic [34:0] acc_mul;
   logic [KW_COUNT-1:0] kw_first, kw_next;
   logic [ExtW-1:0] line_ext;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign c         = req_data.char_code;
   assign eof       = req_data.end_of_input;

   // Position counters after this item
   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (!eof && c == CH_NL) begin
         if (line_ff != {LINE_BITS{1'b1}}) begin
            line_in = line_ff + 1'b1;
         end
         col_in = 16'd0;
      end else if (col_ff != 16'hFFFF) begin
         col_in = col_ff + 16'd1;
      end
   end

   // Common token fields
   assign line_ext = ExtW'(line_in);
   always_comb begin
      base_tok             = '0;
      base_tok.line_number = line_ext[15:0];
      base_tok.column      = col_in;
   end

   // Keyword tracking: first character and following characters
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_first[k] = (c == kw_char(k, 0));
         kw_next[k]  = kw_ff[k] && (int'(cnt_ff) < KW_LEN[k]) &&
                       (c == kw_char(k, int'(cnt_ff)));
      end
   end

   // Identifier or keyword token for the pending word
   always_comb begin
      ident_tok = base_tok;
      if (kw_ff[0] && cnt_ff == CntW'(KW_LEN_INT)) begin
         ident_tok.token_kind = TOK_INT;
      end else if (kw_ff[1] && cnt_ff == CntW'(KW_LEN_VOID)) begin
         ident_tok.token_kind = TOK_VOID;
      end else if (kw_ff[2] && cnt_ff == CntW'(KW_LEN_RETURN)) begin
         ident_tok.token_kind = TOK_RETURN;
      end else begin
         ident_tok.token_kind   = TOK_IDENT;
         ident_tok.ident_length = 7'(cnt_ff);
      end
   end

   // Character seen between tokens
   always_comb begin
      idle_tok   = base_tok;
      idle_emit  = 1'b1;
      idle_mode  = MODE_IDLE;
      idle_digit = 1'b0;
      idle_word  = 1'b0;
      case (c)
         CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF: idle_emit = 1'b0;
         CH_SEMI:   idle_tok.token_kind = TOK_SEMI;
         CH_LPAREN: idle_tok.token_kind = TOK_LPAREN;
         CH_RPAREN: idle_tok.token_kind = TOK_RPAREN;
         CH_LBRACE: idle_tok.token_kind = TOK_LBRACE;
         CH_RBRACE: idle_tok.token_kind = TOK_RBRACE;
         CH_TILDE:  idle_tok.token_kind = TOK_SQUIGGLE;
         CH_MINUS: begin
            idle_emit = 1'b0;
            idle_mode = MODE_MINUS;
         end
         default: begin
            if (is_digit(c)) begin
               idle_emit  = 1'b0;
               idle_mode  = MODE_NUM;
               idle_digit = 1'b1;
            end else if (is_letter(c) || c == CH_UNDER) begin
               idle_emit = 1'b0;
               idle_mode = MODE_IDENT;
               idle_word = 1'b1;
            end else begin
               idle_tok.token_kind     = TOK_BAD;
               idle_tok.offending_char = c;
               idle_mode               = MODE_HALT;
            end
         end
      endcase
   end

   // acc * 10 + digit
   assign acc_mul = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) +
                    35'(c - CH_ZERO);

   // Main scan step
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      kw_in     = kw_ff;
      pend_emit = 1'b0;
      pend_tok  = base_tok;
      do_idle   = 1'b0;
      if (eof) begin
         case (mode_ff)
            MODE_MINUS: begin
               pend_emit           = 1'b1;
               pend_tok.token_kind = TOK_DASH;
            end
            MODE_NUM: begin
               pend_emit                  = 1'b1;
               pend_tok.token_kind        = TOK_CONST;
               pend_tok.constant_value    = acc_ff;
               pend_tok.constant_overflow = ovf_ff;
            end
            MODE_IDENT: begin
               pend_emit = 1'b1;
               pend_tok  = ident_tok;
            end
            default: pend_emit = 1'b0;
         endcase
         mode_in = MODE_HALT;
      end else begin
         case (mode_ff)
            MODE_MINUS: begin
               pend_emit = 1'b1;
               if (c == CH_MINUS) begin
                  pend_tok.token_kind = TOK_DECREMENT;
                  mode_in             = MODE_IDLE;
               end else begin
                  pend_tok.token_kind = TOK_DASH;
                  do_idle             = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(c)) begin
                  if (acc_mul > 35'(CONST_MAX)) begin
                     acc_in = CONST_MAX;
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = acc_mul[30:0];
                  end
               end else if (is_letter(c)) begin
                  pend_emit               = 1'b1;
                  pend_tok.token_kind     = TOK_BAD;
                  pend_tok.offending_char = c;
                  mode_in                 = MODE_HALT;
               end else begin
                  pend_emit                  = 1'b1;
                  pend_tok.token_kind        = TOK_CONST;
                  pend_tok.constant_value    = acc_ff;
                  pend_tok.constant_overflow = ovf_ff;
                  do_idle                    = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_letter(c) || c == CH_UNDER) begin
                  kw_in = kw_next;
                  if (int'(cnt_ff) < MAX_IDENT_LEN) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  pend_emit = 1'b1;
                  pend_tok  = ident_tok;
                  do_idle   = 1'b1;
               end
            end
            MODE_HALT: do_idle = 1'b0;
            default:   do_idle = 1'b1;
         endcase
      end
      if (do_idle) begin
         mode_in = idle_mode;
         if (idle_digit) begin
            acc_in = 31'(c - CH_ZERO);
            ovf_in = 1'b0;
         end
         if (idle_word) begin
            cnt_in = CntW'(1);
            kw_in  = kw_first;
         end
      end
   end

   // Queue entry: pending token first, then the token of this character
   always_comb begin
      logic second;
      second = eof || (do_idle && idle_emit);
      push_entry      = '0;
      push_entry.two  = pend_emit && second;
      push_entry.tok1 = eof ? base_tok : idle_tok;
      if (eof) begin
         push_entry.tok1.token_kind = TOK_EOF;
      end
      push_entry.tok1.last_of_run = 1'b1;
      push_entry.tok0 = pend_emit ? pend_tok : push_entry.tok1;
      push_entry.tok0.last_of_run = !(pend_emit && second);
      push = accept && (mode_ff != MODE_HALT) && (pend_emit || second);
   end

   // State registers; a halted scanner changes nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= '0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= '0;
         kw_ff   <= '1;
         line_ff <= LINE_BITS'(1);
         col_ff  <= '0;
      end else if (accept && mode_ff != MODE_HALT) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         ovf_ff  <= ovf_in;
         cnt_ff  <= cnt_in;
         kw_ff   <= kw_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

endmodule

`default_nettype wire

[design/csl_queue.sv]
// Short FIFO of scanned entries between front end and output stage.
// Uses csl_pkg for the entry type and depth.
`default_nettype none

module csl_queue import csl_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output entry_type      pop_entry
);

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign full      = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ff];

   // Pointer and fill count
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[design/csl_back.sv]
// Output stage: splits queue entries into single tokens and holds the
// result word in a register under stall. Uses csl_pkg.
`default_nettype none

module csl_back import csl_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_empty,
   input  wire entry_type q_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type sec_ff, sec_in;
   logic    sec_valid_ff, sec_valid_in;
   logic    load;

   assign load      = !out_valid_ff || !rsp_stall;
   assign pop       = load && !sec_valid_ff && !q_empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Second token of an entry goes out before the next entry
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      sec_in       = sec_ff;
      sec_valid_in = sec_valid_ff;
      if (load) begin
         if (sec_valid_ff) begin
            out_in       = sec_ff;
            out_valid_in = 1'b1;
            sec_valid_in = 1'b0;
         end else if (!q_empty) begin
            out_in       = q_entry.tok0;
            out_valid_in = 1'b1;
            sec_in       = q_entry.tok1;
            sec_valid_in = q_entry.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

endmodule

`default_nettype wire

[design/c_subset_lexer_core.sv]
// Top level of the C subset lexer: front end, entry queue and output stage.
// Depends on csl_pkg, csl_front, csl_queue and csl_back.
//
// Usage: one source byte (or an end-of-input mark) per req word; tokens
// leave one per rsp word. Each token carries kind, constant value and
// saturation flag, identifier length, offending byte for errors, and the
// line and column after its input byte was counted. last_of_run marks the
// final token caused by one input word.
// Throughput: one input word per cycle while the queue is not full; an
// input that yields two tokens occupies the output once per token, set by the single output register.
// Path: a token's input is written into the queue at the edge that takes
// it, then the output register loads the token from the queue; a second
// token from the same input waits in a second register and follows it.
// Stall: a stalled token holds in the output register; the four-entry
// queue keeps accepting until full, then req_stall rises.
// Reset: scanning state clears, line 1, column 0, queue and output empty.
// After an error or eof token, further input is taken and dropped until
// reset.
`default_nettype none

module c_subset_lexer_core import csl_pkg::*; #(
   parameter int MAX_IDENT_LEN = 64,
   parameter int LINE_BITS     = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic      push, q_full, q_empty, pop;
   entry_type push_entry, pop_entry;

   csl_front #(
      .MAX_IDENT_LEN(MAX_IDENT_LEN),
      .LINE_BITS    (LINE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_entry(push_entry)
   );

   csl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .pop_entry (pop_entry)
   );

   csl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_entry  (pop_entry),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
